// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the tracker checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property checked every cycle out of reset
`define ATT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the following cycle
`define ATT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/att_pkg.sv =====
// types and constants of the acknowledgment timeout tracker
`default_nettype none
package att_pkg;

  localparam int SlotsDef  = 16;
  localparam int ReportMax = 16;

  localparam logic [2:0] OP_TRACK  = 3'd0;
  localparam logic [2:0] OP_ACK    = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_SWEEP  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  localparam logic [1:0] SLOT_FREE    = 2'd0;
  localparam logic [1:0] SLOT_PENDING = 2'd1;
  localparam logic [1:0] SLOT_ACKED   = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] src_node;
    logic [63:0] msg_key;
    logic [15:0] dst_node;
    logic [63:0] send_time;
    logic [63:0] deadline;
    logic [63:0] now;
    logic [4:0]  report_limit;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_source;
    logic [63:0] out_message_id;
    logic [15:0] out_destination;
    logic [63:0] out_send_time;
    logic [4:0]  reported;
    logic [4:0]  occupancy;
    logic [31:0] acks_total;
    logic [31:0] timeouts_total;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] source;
    logic [63:0] message;
    logic [15:0] destination;
    logic [63:0] send_time;
    logic [63:0] deadline;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ack_timeout_tracker.sv =====
// outstanding message table with ack matching and deadline sweep
// sequence: track/ack/cancel/lookup walk the slots from slot 0 and report at the first hit or
//   at the last slot; sweep makes two passes (count, then free and report) and closes in S_CLOSE
// throughput: one item at a time, busy stays high while the slot memory is walked
// reset: asynchronous, all slots free and counters and sweep time zero, no clearing pass
// unknown ops give one result in the cycle after accept
`default_nettype none
module ack_timeout_tracker #(
  parameter int SLOTS = att_pkg::SlotsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire att_pkg::cmd_t cmd_i,
  output logic               strobe_o,
  output att_pkg::res_t      res_o
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);
  localparam logic [4:0] LimMax = 5'(att_pkg::ReportMax);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CNT   = 4'b0010,
    S_WALK  = 4'b0100,
    S_CLOSE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  att_pkg::cmd_t cmd_q, cmd_d;
  logic [IW-1:0] idx_q, idx_d, ev_idx_q, ev_idx_d;
  logic issue_q, issue_d, ev_vld_q, ev_vld_d;
  logic [1:0] st_q [SLOTS];
  logic [1:0] st_d [SLOTS];
  logic [CW-1:0] used_q, used_d, cnt_exp_q, cnt_exp_d, cnt_ack_q, cnt_ack_d;
  logic [31:0] acks_q, acks_d, tmo_q, tmo_d;
  logic [63:0] last_q, last_d;
  logic [4:0] rep_q, rep_d, lim_q, lim_d;
  logic strobe_q, strobe_d;
  att_pkg::res_t res_q, res_d;

  logic we;
  att_pkg::entry_t wentry, rentry;
  logic [CW+4:0] used_ext;
  logic [1:0] est;
  logic match, expd, at_end;

  assign wentry = '{source: cmd_q.src_node, message: cmd_q.msg_key,
                    destination: cmd_q.dst_node, send_time: cmd_q.send_time,
                    deadline: cmd_q.deadline};

  att_ram #(.Width($bits(att_pkg::entry_t)), .Depth(SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ev_idx_q),
    .wdata_i(wentry),
    .re_i   (issue_q),
    .raddr_i(idx_q),
    .rdata_o(rentry)
  );

  assign est    = st_q[ev_idx_q];
  assign match  = (est == att_pkg::SLOT_PENDING) && (rentry.source == cmd_q.src_node) &&
                  (rentry.message == cmd_q.msg_key);
  assign expd   = (est == att_pkg::SLOT_PENDING) && (cmd_q.now >= rentry.deadline);
  assign at_end = (ev_idx_q == LastIdx);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    issue_d   = issue_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    st_d      = st_q;
    used_d    = used_q;
    cnt_exp_d = cnt_exp_q;
    cnt_ack_d = cnt_ack_q;
    acks_d    = acks_q;
    tmo_d     = tmo_q;
    last_d    = last_q;
    rep_d     = rep_q;
    lim_d     = lim_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    we        = 1'b0;
    used_ext  = '0;

    if (issue_q) begin
      ev_vld_d = 1'b1;
      ev_idx_d = idx_q;
      if (idx_q == LastIdx) begin
        issue_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          if (cmd_i.now < last_q) begin
            cmd_d.now = last_q;
          end
          lim_d     = (cmd_i.report_limit > LimMax) ? LimMax : cmd_i.report_limit;
          rep_d     = '0;
          cnt_exp_d = '0;
          cnt_ack_d = '0;
          idx_d     = '0;
          if (cmd_i.op == att_pkg::OP_SWEEP) begin
            last_d  = cmd_d.now;
            state_d = S_CNT;
            issue_d = 1'b1;
          end else if (cmd_i.op <= att_pkg::OP_LOOKUP) begin
            state_d = S_WALK;
            issue_d = 1'b1;
          end else begin
            strobe_d   = 1'b1;
            res_d.last = 1'b1;
          end
        end
      end
      S_CNT: begin
        if (ev_vld_q) begin
          if (expd) begin
            cnt_exp_d = cnt_exp_q + 1'b1;
          end else if (est == att_pkg::SLOT_ACKED) begin
            cnt_ack_d = cnt_ack_q + 1'b1;
          end
          if (at_end) begin
            used_d   = used_q - cnt_exp_d - cnt_ack_d;
            tmo_d    = tmo_q + 32'(cnt_exp_d);
            state_d  = S_WALK;
            idx_d    = '0;
            issue_d  = 1'b1;
            ev_vld_d = 1'b0;
          end
        end
      end
      S_WALK: begin
        if (ev_vld_q) begin
          case (cmd_q.op)
            att_pkg::OP_TRACK: begin
              if (est == att_pkg::SLOT_FREE) begin
                we              = 1'b1;
                st_d[ev_idx_q]  = att_pkg::SLOT_PENDING;
                used_d          = used_q + 1'b1;
                strobe_d        = 1'b1;
                res_d.last      = 1'b1;
                state_d         = S_IDLE;
                issue_d         = 1'b0;
              end else if (at_end) begin
                strobe_d     = 1'b1;
                res_d.status = att_pkg::ST_FULL;
                res_d.last   = 1'b1;
                state_d      = S_IDLE;
              end
            end
            att_pkg::OP_ACK, att_pkg::OP_CANCEL, att_pkg::OP_LOOKUP: begin
              if (match) begin
                if (cmd_q.op == att_pkg::OP_ACK) begin
                  st_d[ev_idx_q] = att_pkg::SLOT_ACKED;
                  acks_d         = acks_q + 32'd1;
                end else if (cmd_q.op == att_pkg::OP_CANCEL) begin
                  st_d[ev_idx_q] = att_pkg::SLOT_FREE;
                  if (used_q != '0) begin
                    used_d = used_q - 1'b1;
                  end
                end else begin
                  res_d.out_destination = rentry.destination;
                  res_d.out_send_time   = rentry.send_time;
                end
                strobe_d   = 1'b1;
                res_d.last = 1'b1;
                state_d    = S_IDLE;
                issue_d    = 1'b0;
              end else if (at_end) begin
                strobe_d     = 1'b1;
                res_d.status = att_pkg::ST_NOMATCH;
                res_d.last   = 1'b1;
                state_d      = S_IDLE;
              end
            end
            att_pkg::OP_SWEEP: begin
              if (expd) begin
                st_d[ev_idx_q] = att_pkg::SLOT_FREE;
                if (rep_q < lim_q) begin
                  strobe_d              = 1'b1;
                  res_d.out_source      = rentry.source;
                  res_d.out_message_id  = rentry.message;
                  res_d.out_destination = rentry.destination;
                  res_d.out_send_time   = rentry.send_time;
                  rep_d                 = rep_q + 5'd1;
                end
              end else if (est == att_pkg::SLOT_ACKED) begin
                st_d[ev_idx_q] = att_pkg::SLOT_FREE;
              end
              if (at_end) begin
                state_d = S_CLOSE;
              end
            end
            default: begin
              state_d = S_IDLE;
              issue_d = 1'b0;
            end
          endcase
        end
      end
      S_CLOSE: begin
        strobe_d       = 1'b1;
        res_d.reported = rep_q;
        res_d.last     = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
        issue_d = 1'b0;
      end
    endcase

    used_ext             = {5'b0, used_d};
    res_d.occupancy      = used_ext[4:0];
    res_d.acks_total     = acks_d;
    res_d.timeouts_total = tmo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issue_q   <= 1'b0;
      ev_vld_q  <= 1'b0;
      used_q    <= '0;
      cnt_exp_q <= '0;
      cnt_ack_q <= '0;
      acks_q    <= '0;
      tmo_q     <= '0;
      last_q    <= '0;
      rep_q     <= '0;
      strobe_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= att_pkg::SLOT_FREE;
      end
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      ev_vld_q  <= ev_vld_d;
      used_q    <= used_d;
      cnt_exp_q <= cnt_exp_d;
      cnt_ack_q <= cnt_ack_d;
      acks_q    <= acks_d;
      tmo_q     <= tmo_d;
      last_q    <= last_d;
      rep_q     <= rep_d;
      strobe_q  <= strobe_d;
      st_q      <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    ev_idx_q <= ev_idx_d;
    lim_q    <= lim_d;
    res_q    <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
  assign res_o    = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/att_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module att_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [Width-1:0]       wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AW-1:0]          raddr_i,
  output logic      [Width-1:0]       rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/att_checker.sv =====
// port-level checks of the tracker, bound into each tracker instance
`default_nettype none
`include "assert_macros.svh"
module att_checker #(
  parameter int SLOTS = att_pkg::SlotsDef
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire att_pkg::cmd_t cmd_i,
  input wire logic          strobe_o,
  input wire att_pkg::res_t res_o
);
  localparam logic [4:0] SlotsLow = 5'(SLOTS);

  `ATT_ASSERT(a_status_code, !strobe_o || (res_o.status != 2'd3), "undefined status code")
  `ATT_ASSERT(a_report_busy, !(strobe_o && !res_o.last) || busy, "report outside a sweep")
  `ATT_ASSERT(a_report_fields, !(strobe_o && !res_o.last) || ((res_o.reported == 5'd0) && (res_o.status == att_pkg::ST_OK)), "bad report result")
  `ATT_ASSERT(a_full_occ, !(strobe_o && res_o.status == att_pkg::ST_FULL) || (res_o.occupancy == SlotsLow), "full with free slots")
  `ATT_ASSERT_NEXT(a_accept_busy, start && !busy && (cmd_i.op <= att_pkg::OP_SWEEP), busy, "walk did not start")
endmodule

bind ack_timeout_tracker att_checker #(.SLOTS(SLOTS)) u_att_checker (.*);
`default_nettype wire

// ===== tb/tb_ack_timeout_tracker.sv =====
// testbench for the acknowledgment timeout tracker with a table predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_ack_timeout_tracker;

  localparam int NSLOT = att_pkg::SlotsDef;
  localparam int STALL_LIMIT = 2000;

  class msg_table_sb;
    logic [1:0]       sstat [NSLOT];
    att_pkg::entry_t  sent  [NSLOT];
    logic [4:0]       used;
    logic [31:0]      acks;
    logic [31:0]      touts;
    logic [63:0]      sweep_t;
    att_pkg::res_t    pending_q [$];
    int               errors;

    function void clear();
      foreach (sstat[i]) sstat[i] = att_pkg::SLOT_FREE;
      used = '0; acks = '0; touts = '0; sweep_t = '0; errors = 0;
      pending_q.delete();
    endfunction

    function int find_key(att_pkg::cmd_t c);
      for (int i = 0; i < NSLOT; i++)
        if (sstat[i] == att_pkg::SLOT_PENDING && sent[i].source == c.src_node &&
            sent[i].message == c.msg_key) return i;
      return -1;
    endfunction

    function void note_cmd(att_pkg::cmd_t c);
      att_pkg::res_t r;
      att_pkg::res_t batch [$];
      int m;
      int lim;
      logic [63:0] t;
      logic [4:0] rep;
      lim = (c.report_limit > att_pkg::ReportMax) ? att_pkg::ReportMax : c.report_limit;
      if (c.op == att_pkg::OP_SWEEP) begin
        rep = '0;
        t = (c.now < sweep_t) ? sweep_t : c.now;
        sweep_t = t;
        for (int i = 0; i < NSLOT; i++) begin
          if (sstat[i] == att_pkg::SLOT_PENDING && t >= sent[i].deadline) begin
            if (rep < lim) begin
              r = '0;
              r.out_source = sent[i].source;
              r.out_message_id = sent[i].message;
              r.out_destination = sent[i].destination;
              r.out_send_time = sent[i].send_time;
              batch.push_back(r);
              rep++;
            end
            touts++;
            sstat[i] = att_pkg::SLOT_FREE;
            if (used != 0) used--;
          end else if (sstat[i] == att_pkg::SLOT_ACKED) begin
            sstat[i] = att_pkg::SLOT_FREE;
            if (used != 0) used--;
          end
        end
        r = '0; r.reported = rep; r.last = 1'b1;
        batch.push_back(r);
      end else begin
        r = '0; r.last = 1'b1;
        if (c.op == att_pkg::OP_TRACK) begin
          m = -1;
          for (int i = 0; i < NSLOT; i++)
            if (m < 0 && sstat[i] == att_pkg::SLOT_FREE) m = i;
          if (m < 0) r.status = att_pkg::ST_FULL;
          else begin
            sstat[m] = att_pkg::SLOT_PENDING;
            sent[m] = '{c.src_node, c.msg_key, c.dst_node, c.send_time, c.deadline};
            used++;
          end
        end else if (c.op == att_pkg::OP_ACK || c.op == att_pkg::OP_CANCEL ||
                     c.op == att_pkg::OP_LOOKUP) begin
          m = find_key(c);
          if (m < 0) r.status = att_pkg::ST_NOMATCH;
          else if (c.op == att_pkg::OP_ACK) begin
            sstat[m] = att_pkg::SLOT_ACKED; acks++;
          end else if (c.op == att_pkg::OP_CANCEL) begin
            sstat[m] = att_pkg::SLOT_FREE;
            if (used != 0) used--;
          end else begin
            r.out_destination = sent[m].destination;
            r.out_send_time = sent[m].send_time;
          end
        end
        batch.push_back(r);
      end
      foreach (batch[k]) begin
        batch[k].occupancy = used;
        batch[k].acks_total = acks;
        batch[k].timeouts_total = touts;
        pending_q.push_back(batch[k]);
      end
    endfunction

    function void check_res(att_pkg::res_t got);
      att_pkg::res_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  att_pkg::cmd_t cmd_i = '0;
  logic strobe_o;
  att_pkg::res_t res_o;
  msg_table_sb sb;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  logic [15:0] src_pool [4];
  logic [63:0] msg_pool [4];
  logic [63:0] clock_us = 64'd1000;

  ack_timeout_tracker dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .strobe_o(strobe_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) sb.check_res(res_o);
      if (strobe_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("tb_ack_timeout_tracker NOT OK");
        $finish;
      end
    end
  end

  function automatic att_pkg::cmd_t rand_fill();
    logic [383:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return att_pkg::cmd_t'(raw[$bits(att_pkg::cmd_t)-1:0]);
  endfunction

  task automatic send_cmd(att_pkg::cmd_t c);
    while (!quiet && $urandom_range(99) < 14) @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_cmd(c);
    @(negedge clk_i);
    start <= 1'b0;
    cmd_i <= rand_fill();
    @(negedge clk_i);
  endtask

  function automatic att_pkg::cmd_t rand_cmd();
    att_pkg::cmd_t c;
    int p;
    c = rand_fill();
    p = $urandom_range(3);
    c.src_node = src_pool[p];
    c.msg_key = ($urandom_range(3) == 0) ? msg_pool[$urandom_range(3)] : msg_pool[p];
    c.report_limit = 5'($urandom_range(20));
    c.send_time = clock_us;
    c.deadline = clock_us + 64'($urandom_range(400));
    if ($urandom_range(15) == 0) c.deadline = {$urandom, $urandom};
    c.now = clock_us + 64'($urandom_range(300));
    if ($urandom_range(10) == 0) c.now = 64'($urandom_range(500));
    if ($urandom_range(20) == 0) c.now = '1;
    case ($urandom_range(19)) inside
      [0:6]: c.op = att_pkg::OP_TRACK;
      [7:10]: c.op = att_pkg::OP_ACK;
      [11:12]: c.op = att_pkg::OP_CANCEL;
      [13:15]: c.op = att_pkg::OP_LOOKUP;
      [16:18]: c.op = att_pkg::OP_SWEEP;
      default: c.op = 3'($urandom_range(5, 7));
    endcase
    return c;
  endfunction

  initial begin
    att_pkg::cmd_t c;
    sb = new();
    sb.clear();
    for (int i = 0; i < 4; i++) begin
      src_pool[i] = 16'($urandom);
      msg_pool[i] = {$urandom, $urandom};
    end
    src_pool[0] = '0; src_pool[1] = '1; msg_pool[0] = '0; msg_pool[1] = '1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    c = '0; c.op = att_pkg::OP_LOOKUP; send_cmd(c);
    for (int i = 0; i < NSLOT + 1; i++) begin
      c = '0;
      c.op = att_pkg::OP_TRACK;
      c.src_node = (i == 1) ? 16'hffff : 16'd0;
      c.msg_key = (i == 1) ? '1 : 64'(i % 3);
      c.dst_node = (i == 2) ? 16'hffff : 16'(i);
      c.send_time = (i == 2) ? '1 : 64'(i);
      c.deadline = (i < 4) ? 64'd0 : ((i == 5) ? '1 : 64'(100 + i));
      send_cmd(c);
    end
    c = '0; c.op = att_pkg::OP_LOOKUP; c.msg_key = 64'd1; send_cmd(c);
    c.op = att_pkg::OP_ACK; send_cmd(c);
    c.op = att_pkg::OP_CANCEL; c.msg_key = 64'd2; send_cmd(c);
    c.op = att_pkg::OP_ACK; c.src_node = 16'd7; send_cmd(c);
    c = '0; c.op = 3'd7; send_cmd(c);
    c = '0; c.op = att_pkg::OP_SWEEP; c.now = 64'd110; c.report_limit = 5'd2; send_cmd(c);
    c.now = 64'd0; c.report_limit = 5'd31; send_cmd(c);
    c.now = '1; c.report_limit = 5'd16; send_cmd(c);

    for (int n = 0; n < 104; n++) begin
      quiet = (n >= 40 && n < 70);
      clock_us = clock_us + 64'($urandom_range(60));
      send_cmd(rand_cmd());
    end
    quiet = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * NSLOT + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_ack_timeout_tracker OK");
    end else begin
      $display("tb_ack_timeout_tracker NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
